// File: rtl/sws_pkg.sv
// Shared types and codes for the stop-and-wait sender.
package sws_pkg;

  localparam int FrameW = 16;
  localparam int TimeW  = 16;
  localparam int RetryW = 8;
  localparam int CfgW   = 16;

  // Request opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_ACK   = 2'd1;
  localparam logic [1:0] OP_NACK  = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // Phases
  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_HANDSHAKE = 2'd1;
  localparam logic [1:0] PH_SENDING   = 2'd2;
  localparam logic [1:0] PH_WAIT      = 2'd3;

  // Result events
  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_HS_SENT    = 3'd1;
  localparam logic [2:0] EV_FRAME_SENT = 3'd2;
  localparam logic [2:0] EV_HS_FAIL    = 3'd3;
  localparam logic [2:0] EV_ACK        = 3'd4;
  localparam logic [2:0] EV_RETRY      = 3'd5;
  localparam logic [2:0] EV_SEND_FAIL  = 3'd6;
  localparam logic [2:0] EV_DONE       = 3'd7;

  // Configuration register indexes
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_RETRY   = 1'b1;

  localparam logic [TimeW-1:0]  TIMEOUT_RESET = 16'd1000;
  localparam logic [RetryW-1:0] RETRY_RESET   = 8'd3;
  localparam logic [TimeW-1:0]  ELAPSED_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [2:0]        ev;
    logic [FrameW-1:0] idx;
    logic [1:0]        phase;
  } res_t;

endpackage

// File: rtl/sws_core.sv
// Transfer state registers and the per-request next-state logic.
module sws_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [1:0]                 opcode,
  input  logic [sws_pkg::FrameW-1:0] frame_total,
  input  logic [sws_pkg::TimeW-1:0]  timeout_ticks,
  input  logic [sws_pkg::RetryW-1:0] retry_limit,
  output sws_pkg::res_t              res
);
  import sws_pkg::*;

  logic [1:0]        phase_reg, phase_reg_next;
  logic [FrameW-1:0] frames_acked, frames_acked_next;
  logic [RetryW-1:0] retry_count, retry_count_next;
  logic [TimeW-1:0]  elapsed_ticks, elapsed_ticks_next;
  logic [FrameW-1:0] frames_wanted, frames_wanted_next;

  logic [FrameW-1:0] acked_inc;
  logic [RetryW:0]   retry_inc;
  logic              retry_ok;
  logic [TimeW-1:0]  elapsed_inc;
  logic              clear;

  assign acked_inc   = frames_acked + 1'b1;
  assign retry_inc   = {1'b0, retry_count} + 1'b1;
  assign retry_ok    = !(retry_inc > {1'b0, retry_limit});
  assign elapsed_inc = (elapsed_ticks < ELAPSED_MAX) ? elapsed_ticks + 1'b1 : elapsed_ticks;

  always_comb begin
    phase_reg_next     = phase_reg;
    frames_acked_next  = frames_acked;
    retry_count_next   = retry_count;
    elapsed_ticks_next = elapsed_ticks;
    frames_wanted_next = frames_wanted;
    clear              = 1'b0;
    res.ev             = EV_NONE;
    res.idx            = frames_acked;
    case (opcode)
      OP_START: begin
        if (phase_reg == PH_IDLE) begin
          retry_count_next   = '0;
          elapsed_ticks_next = '0;
          frames_acked_next  = '0;
          frames_wanted_next = frame_total;
          phase_reg_next     = PH_HANDSHAKE;
          res.ev             = EV_HS_SENT;
          res.idx            = '0;
        end
      end
      OP_ACK: begin
        if (phase_reg == PH_HANDSHAKE) begin
          phase_reg_next = PH_SENDING;
        end else if (phase_reg == PH_WAIT) begin
          res.idx = acked_inc;
          if (acked_inc == frames_wanted) begin
            res.ev = EV_DONE;
            clear  = 1'b1;
          end else begin
            res.ev            = EV_ACK;
            frames_acked_next = acked_inc;
            retry_count_next  = '0;
            phase_reg_next    = PH_SENDING;
          end
        end
      end
      OP_NACK: begin
        if (phase_reg == PH_HANDSHAKE) begin
          res.ev = EV_HS_FAIL;
          clear  = 1'b1;
        end else if (phase_reg == PH_WAIT) begin
          if (retry_ok) begin
            res.ev           = EV_RETRY;
            retry_count_next = retry_inc[RetryW-1:0];
            phase_reg_next   = PH_SENDING;
          end else begin
            res.ev = EV_SEND_FAIL;
            clear  = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (phase_reg == PH_SENDING) begin
          res.ev             = EV_FRAME_SENT;
          elapsed_ticks_next = '0;
          phase_reg_next     = PH_WAIT;
        end else if (phase_reg != PH_IDLE) begin
          elapsed_ticks_next = elapsed_inc;
          if (elapsed_inc >= timeout_ticks) begin
            if (phase_reg == PH_HANDSHAKE) begin
              res.ev = EV_HS_FAIL;
              clear  = 1'b1;
            end else if (retry_ok) begin
              res.ev           = EV_RETRY;
              retry_count_next = retry_inc[RetryW-1:0];
              phase_reg_next   = PH_SENDING;
            end else begin
              res.ev = EV_SEND_FAIL;
              clear  = 1'b1;
            end
          end
        end
      end
      default: begin
        res.ev = EV_NONE;
      end
    endcase
    // End of transfer: drop all transfer state.
    if (clear) begin
      phase_reg_next     = PH_IDLE;
      frames_acked_next  = '0;
      retry_count_next   = '0;
      elapsed_ticks_next = '0;
      frames_wanted_next = '0;
    end
    res.phase = phase_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_IDLE;
      frames_acked  <= '0;
      retry_count   <= '0;
      elapsed_ticks <= '0;
      frames_wanted <= '0;
    end else if (accept) begin
      phase_reg     <= phase_reg_next;
      frames_acked  <= frames_acked_next;
      retry_count   <= retry_count_next;
      elapsed_ticks <= elapsed_ticks_next;
      frames_wanted <= frames_wanted_next;
    end
  end

endmodule

// File: rtl/stop_and_wait_sender_unit.sv
// Stop-and-wait sender: configuration registers, core state and result register.
// Results are registered and show from the cycle after the request is accepted.
// Throughput: one request per cycle unless stalled; the transfer state updates in
//   one pass of the core's next-state logic; the result register drains in parallel.
// Reset: rst (synchronous) returns the sender to idle, clears all counters,
//   empties the result register and loads timeout 1000 and retry limit 3.
module stop_and_wait_sender_unit (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration write port
  input  logic                       cfg_write,
  input  logic                       cfg_index,
  input  logic [sws_pkg::CfgW-1:0]   cfg_data,
  // Request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 opcode,
  input  logic [sws_pkg::FrameW-1:0] frame_total,
  // Result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 event_res,
  output logic [sws_pkg::FrameW-1:0] frame_index,
  output logic [1:0]                 phase
);
  import sws_pkg::*;

  logic [TimeW-1:0]  timeout_ticks;
  logic [RetryW-1:0] retry_limit;
  logic              accept;
  res_t              res_comb;
  res_t              res_q;

  // Config regs; user must write them only while the sender is quiet (unchecked).
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      retry_limit   <= RETRY_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TIMEOUT: timeout_ticks <= cfg_data[TimeW-1:0];
        CFG_RETRY:   retry_limit   <= cfg_data[RetryW-1:0];
        default:     timeout_ticks <= timeout_ticks;
      endcase
    end
  end

  // Hold off a new request only while a result waits and the consumer stalls;
  // an empty or draining result register takes the next request at once.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  sws_core u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .opcode       (opcode),
    .frame_total  (frame_total),
    .timeout_ticks(timeout_ticks),
    .retry_limit  (retry_limit),
    .res          (res_comb)
  );

  // Result register: load on accept, hold while stalled, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res_comb;
    end
  end

  assign event_res   = res_q.ev;
  assign frame_index = res_q.idx;
  assign phase       = res_q.phase;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the stop-and-wait sender unit.
`timescale 1ns / 100ps

module testbench;
  import sws_pkg::*;

  // Requests waiting to be driven, filled by the stimulus process.
  typedef struct {
    logic [1:0]        op;
    logic [FrameW-1:0] total;
  } request_t;

  // Which side of the handshake idles, and how often.
  typedef enum {RECV_MOSTLY_IDLE, SEND_MOSTLY_IDLE, NO_IDLE} idle_mode_t;

  localparam int QuietLimit = 5000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic              cfg_index = CFG_TIMEOUT;
  logic [CfgW-1:0]   cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        opcode = OP_TICK;
  logic [FrameW-1:0] frame_total = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        event_res;
  logic [FrameW-1:0] frame_index;
  logic [1:0]        phase;

  stop_and_wait_sender_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .frame_total (frame_total),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_res   (event_res),
    .frame_index (frame_index),
    .phase       (phase)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  request_t   pending_requests[$];
  res_t       expected_events[$];
  idle_mode_t idle_mode = NO_IDLE;
  int         requests_queued = 0;
  int         requests_taken = 0;
  int         results_seen = 0;
  int         error_count = 0;
  int         event_hits[8];

  // Mirror of the configuration registers, updated as they are written.
  logic [TimeW-1:0]  timeout_cfg;
  logic [RetryW-1:0] retry_cfg;

  // Transfer state as the sender should hold it.
  logic [1:0]        tx_phase;
  logic [FrameW-1:0] tx_acked;
  logic [RetryW-1:0] tx_retries;
  logic [TimeW-1:0]  tx_elapsed;
  logic [FrameW-1:0] tx_wanted;

  // ---------------------------------------------------------------------------
  // Transfer predictor
  // ---------------------------------------------------------------------------

  // Drop the transfer back to idle; the registers keep their values.
  function automatic void clear_transfer();
    tx_phase   = PH_IDLE;
    tx_acked   = '0;
    tx_retries = '0;
    tx_elapsed = '0;
    tx_wanted  = '0;
  endfunction

  // A NACK or a timeout while waiting: retry the frame, or give up once the
  // bumped count passes the limit. The count is compared one bit wider so
  // that a limit of 255 still fails on the 256th retry instead of wrapping.
  function automatic logic [2:0] retry_frame();
    logic [RetryW:0] bumped;
    bumped = {1'b0, tx_retries} + 1'b1;
    if (bumped > {1'b0, retry_cfg}) begin
      clear_transfer();
      return EV_SEND_FAIL;
    end
    tx_retries = bumped[RetryW-1:0];
    tx_phase   = PH_SENDING;
    return EV_RETRY;
  endfunction

  // Advance the transfer by one request and return the result it must cause.
  function automatic res_t predict_sender(input logic [1:0] op,
                                          input logic [FrameW-1:0] total);
    res_t r;
    r.ev  = EV_NONE;
    r.idx = tx_acked;
    case (op)
      OP_START: begin
        // a start while busy is ignored
        if (tx_phase == PH_IDLE) begin
          clear_transfer();
          tx_wanted = total;
          tx_phase  = PH_HANDSHAKE;
          r.ev      = EV_HS_SENT;
          r.idx     = '0;
        end
      end
      OP_ACK: begin
        if (tx_phase == PH_HANDSHAKE) begin
          tx_phase = PH_SENDING;
        end else if (tx_phase == PH_WAIT) begin
          // the count wraps, so a total of zero behaves as 65536 frames
          tx_acked   = tx_acked + 1'b1;
          tx_retries = '0;
          r.idx      = tx_acked;
          if (tx_acked == tx_wanted) begin
            r.ev = EV_DONE;
            clear_transfer();
          end else begin
            r.ev     = EV_ACK;
            tx_phase = PH_SENDING;
          end
        end
      end
      OP_NACK: begin
        if (tx_phase == PH_HANDSHAKE) begin
          r.ev = EV_HS_FAIL;
          clear_transfer();
        end else if (tx_phase == PH_WAIT) begin
          r.ev = retry_frame();
        end
      end
      default: begin
        if (tx_phase == PH_SENDING) begin
          r.ev       = EV_FRAME_SENT;
          tx_elapsed = '0;
          tx_phase   = PH_WAIT;
        end else if (tx_phase != PH_IDLE) begin
          // count the tick first, saturating, then compare
          if (tx_elapsed != ELAPSED_MAX) tx_elapsed = tx_elapsed + 1'b1;
          if (tx_elapsed >= timeout_cfg) begin
            if (tx_phase == PH_HANDSHAKE) begin
              r.ev = EV_HS_FAIL;
              clear_transfer();
            end else begin
              r.ev = retry_frame();
            end
          end
        end
      end
    endcase
    r.phase = tx_phase;
    return r;
  endfunction

  function automatic int unsigned gap_pct(input bit for_sender);
    case (idle_mode)
      RECV_MOSTLY_IDLE: return for_sender ? 24 : 84;
      SEND_MOSTLY_IDLE: return for_sender ? 84 : 24;
      default:          return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: predict each request as it is taken, then offer the next
  // one from the pending queue or go idle. A stalled request is held as is.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    request_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_events.push_back(predict_sender(opcode, frame_total));
        requests_taken++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled request
      end else if (pending_requests.size() != 0 &&
                   $urandom_range(0, 99) >= gap_pct(1'b1)) begin
        nxt = pending_requests.pop_front();
        in_valid    <= 1'b1;
        opcode      <= nxt.op;
        frame_total <= nxt.total;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each taken result with the oldest expectation and
  // drive the stall. Twice in the run it holds off for a long stretch so the
  // result register fills and the sender backs up behind it.
  // ---------------------------------------------------------------------------
  int hold_left = 0;

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        event_hits[event_res]++;
        if (expected_events.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result ev %0d idx %0d phase %0d",
                   $time, event_res, frame_index, phase);
        end else begin
          want = expected_events.pop_front();
          if (want !== {event_res, frame_index, phase}) begin
            error_count++;
            $display("%0t: mismatch expected ev %0d idx %0d phase %0d,",
                     $time, want.ev, want.idx, want.phase,
                     " got ev %0d idx %0d phase %0d",
                     event_res, frame_index, phase);
          end
        end
        if (results_seen == 400 || results_seen == 1200)
          hold_left = 150 + $urandom_range(0, 50);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < gap_pct(1'b0));
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no progress for %0d cycles", $time, QuietLimit);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_req(input logic [1:0] op, input logic [FrameW-1:0] total);
    request_t r;
    r.op    = op;
    r.total = total;
    pending_requests.push_back(r);
    requests_queued++;
  endtask

  // Write one register; only called with nothing in flight.
  task automatic write_reg(input logic idx, input logic [CfgW-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == CFG_TIMEOUT) timeout_cfg = value[TimeW-1:0];
    else retry_cfg = value[RetryW-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Pause the stimulus until every request is taken and every result is back.
  task automatic wait_drain();
    @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_events.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Let the reply timer run out; with long timeouts use a NACK instead.
  task automatic push_timeout();
    if (timeout_cfg > 8) begin
      push_req(OP_NACK, $urandom);
    end else begin
      repeat ((timeout_cfg == 0) ? 1 : timeout_cfg) push_req(OP_TICK, $urandom);
    end
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 99) < 8) push_req($urandom_range(0, 3), $urandom);
  endtask

  // Mostly well-formed transfers with random content, some broken ones, and
  // random noise between steps.
  task automatic gen_transfers(input int count);
    int goal;
    int frames;
    int pick;
    logic [FrameW-1:0] total;
    goal = requests_queued + count;
    while (requests_queued < goal) begin
      pick  = $urandom_range(0, 99);
      total = $urandom_range(1, 4);
      // huge or zero totals are truncated and aborted, only when that is cheap
      if (pick < 5 && retry_cfg <= 8) total = $urandom;
      push_req(OP_START, total);
      maybe_noise();
      if ($urandom_range(0, 9) == 0) begin
        // broken handshake: refused or left to time out
        if ($urandom_range(0, 1)) push_req(OP_NACK, $urandom);
        else push_timeout();
        continue;
      end
      if (timeout_cfg > 1 && $urandom_range(0, 3) == 0) push_req(OP_TICK, $urandom);
      push_req(OP_ACK, $urandom);
      frames = (total == 0 || total > 5) ? 5 : total;
      for (int f = 0; f < frames; f++) begin
        maybe_noise();
        push_req(OP_TICK, $urandom);
        forever begin
          pick = $urandom_range(0, 99);
          if (pick < 75) break;
          if (pick < 88) push_req(OP_NACK, $urandom);
          else push_timeout();
          push_req(OP_TICK, $urandom);
        end
        push_req(OP_ACK, $urandom);
      end
      // a truncated transfer is ended by running out its retries
      if (total == 0 || total > 5) begin
        repeat (retry_cfg + 1) begin
          push_req(OP_TICK, $urandom);
          push_req(OP_NACK, $urandom);
        end
      end
    end
  endtask

  task automatic run_phase(input logic [TimeW-1:0] tmo, input logic [RetryW-1:0] lim,
                           input idle_mode_t mode, input int count);
    wait_drain();
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_RETRY, {{(CfgW-RetryW){1'b0}}, lim});
    @(negedge clk);
    idle_mode = mode;
    gen_transfers(count);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    timeout_cfg = TIMEOUT_RESET;
    retry_cfg   = RETRY_RESET;
    clear_transfer();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed walk with a short timer and a single allowed retry.
    write_reg(CFG_TIMEOUT, 16'd3);
    write_reg(CFG_RETRY, 16'd1);
    @(negedge clk);
    idle_mode = RECV_MOSTLY_IDLE;
    push_req(OP_TICK, 16'hFFFF);   // tick while idle
    push_req(OP_ACK, 16'h0000);    // ACK while idle
    push_req(OP_NACK, 16'hFFFF);   // NACK while idle
    push_req(OP_START, 16'd2);
    push_req(OP_START, 16'hFFFF);  // start while busy
    push_req(OP_TICK, 16'h0000);   // handshake timer counts
    push_req(OP_ACK, 16'h0000);    // handshake accepted
    push_req(OP_ACK, 16'h0000);    // ACK while sending
    push_req(OP_NACK, 16'h0000);   // NACK while sending
    push_req(OP_TICK, 16'h0000);   // frame 0 out
    push_req(OP_ACK, 16'h0000);
    push_req(OP_TICK, 16'h0000);   // frame 1 out
    push_req(OP_NACK, 16'h0000);   // first retry
    push_req(OP_TICK, 16'h0000);
    repeat (3) push_req(OP_TICK, 16'h0000);  // timeout past the limit fails
    push_req(OP_START, 16'hFFFF);
    push_req(OP_NACK, 16'h0000);   // handshake refused
    push_req(OP_START, 16'd1);
    repeat (3) push_req(OP_TICK, 16'h0000);  // handshake times out
    push_req(OP_START, 16'd0);     // zero total wraps to 65536 frames
    push_req(OP_ACK, 16'h0000);
    push_req(OP_TICK, 16'h0000);
    push_req(OP_ACK, 16'h0000);

    // Random phases, one register setting each.
    run_phase(16'd2, 8'd0, RECV_MOSTLY_IDLE, 300);
    run_phase(16'd5, 8'd3, SEND_MOSTLY_IDLE, 300);
    run_phase(16'd1, 8'd2, NO_IDLE, 250);
    run_phase(16'd0, 8'd1, RECV_MOSTLY_IDLE, 100);

    // Widest settings: exhaust all 255 retries of one frame, then carry on.
    wait_drain();
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    write_reg(CFG_RETRY, 16'd255);
    @(negedge clk);
    idle_mode = NO_IDLE;
    push_req(OP_START, 16'd1);
    push_req(OP_ACK, $urandom);
    repeat (256) begin
      push_req(OP_TICK, $urandom);
      push_req(OP_NACK, $urandom);
    end
    gen_transfers(100);

    run_phase(16'd3, 8'd4, SEND_MOSTLY_IDLE, 200);

    wait_drain();
    repeat (4) @(posedge clk);
    $display("covered %0d requests, %0d results, timeouts 0..65535, retry limits 0..255",
             requests_taken, results_seen);
    $display("events: none %0d hs %0d frame %0d hsfail %0d ack %0d retry %0d fail %0d done %0d",
             event_hits[EV_NONE], event_hits[EV_HS_SENT], event_hits[EV_FRAME_SENT],
             event_hits[EV_HS_FAIL], event_hits[EV_ACK], event_hits[EV_RETRY],
             event_hits[EV_SEND_FAIL], event_hits[EV_DONE]);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
